### rtl/kpvb_pkg.sv
// Shared types, constants and helpers for the position/velocity/baro Kalman filter.
// Depends on nothing; kpvb_mac, kpvb_div and the top level refer to it by scoped names.
`default_nettype none

package kpvb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NX        = 6;
    localparam int ADDR_W    = 6;
    localparam int NUM_CFG   = 8;
    localparam int DIV_W     = 32 + FRAC_BITS;
    localparam int DT2_W     = 19;

    localparam logic [1:0] OP_INIT    = 2'd0;
    localparam logic [1:0] OP_PREDICT = 2'd1;
    localparam logic [1:0] OP_UPDATE  = 2'd2;

    localparam logic [2:0] CFG_MEAS_NOISE = 3'd6;
    localparam logic [2:0] CFG_INIT_COV   = 3'd7;

    localparam logic [30:0] CFG_RESET [NUM_CFG] = '{
        31'd1311, 31'd2621, 31'd1966, 31'd26214,
        31'd23593, 31'd20972, 31'd19661, 31'd6554
    };

    typedef enum logic [13:0] {
        PH_IDLE = 14'b00000000000001,
        PH_CLR  = 14'b00000000000010,
        PH_DT2  = 14'b00000000000100,
        PH_PST  = 14'b00000000001000,
        PH_CA   = 14'b00000000010000,
        PH_CB   = 14'b00000000100000,
        PH_CQ   = 14'b00000001000000,
        PH_S    = 14'b00000010000000,
        PH_GAIN = 14'b00000100000000,
        PH_RES  = 14'b00001000000000,
        PH_XUPD = 14'b00010000000000,
        PH_ROW1 = 14'b00100000000000,
        PH_CUPD = 14'b01000000000000,
        PH_FIN  = 14'b10000000000000
    } phase_t;

    typedef enum logic [3:0] {
        ST_RA   = 4'b0001,
        ST_RB   = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_POST = 4'b1000
    } step_t;

    typedef enum logic [1:0] {
        POST_ADD,
        POST_SUB,
        POST_POS,
        POST_HOLD
    } post_op_t;

    typedef struct packed {
        logic     mul_en;
        logic     hold_en;
        post_op_t op;
    } mac_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] max_v;
        logic signed [65:0] min_v;
        max_v = 66'sd2147483647;
        min_v = -66'sd2147483648;
        if (v > max_v) begin
            return 32'sh7FFF_FFFF;
        end else if (v < min_v) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Row-major address of covariance entry (r, c).
    function automatic logic [ADDR_W-1:0] cov_idx(input logic [2:0] r, input logic [2:0] c);
        logic [ADDR_W-1:0] rr;
        rr = {3'b000, r};
        return (rr << 2) + (rr << 1) + {3'b000, c};
    endfunction

endpackage

`default_nettype wire

### rtl/kpvb_mac.sv
// Shared multiply unit: one registered 32x32 signed product, then a rounded
// add, subtract or position step with saturation. Depends on kpvb_pkg.
`default_nettype none

module kpvb_mac (
    input  wire logic                     aclk,
    input  wire kpvb_pkg::mac_ctl_t       ctl,
    input  wire logic signed [31:0]       opa,
    input  wire logic signed [31:0]       opb,
    input  wire logic signed [31:0]       addend,
    output logic signed [31:0]            y
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] rnd_v;
    logic signed [63:0] pos_v;
    logic signed [65:0] delta;
    logic signed [65:0] sum;

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= opa * opb;
        end
        if (ctl.hold_en) begin
            acc_reg <= prod_reg;
        end
    end

    always_comb begin
        rnd_v = (prod_reg + (64'sd1 <<< (kpvb_pkg::FRAC_BITS - 1))) >>> kpvb_pkg::FRAC_BITS;
        // Position step: twice the current product plus the held-back product,
        // rounded by one more bit.
        pos_v = ((prod_reg <<< 1) + acc_reg + (64'sd1 <<< kpvb_pkg::FRAC_BITS))
                >>> (kpvb_pkg::FRAC_BITS + 1);
        case (ctl.op)
            kpvb_pkg::POST_SUB: delta = -{{2{rnd_v[63]}}, rnd_v};
            kpvb_pkg::POST_POS: delta = {{2{pos_v[63]}}, pos_v};
            default:            delta = {{2{rnd_v[63]}}, rnd_v};
        endcase
        sum = {{34{addend[31]}}, addend} + delta;
        y   = kpvb_pkg::sat32(sum);
    end

endmodule

`default_nettype wire

### rtl/kpvb_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, for the Kalman gain.
// Depends on kpvb_pkg.
`default_nettype none

module kpvb_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [kpvb_pkg::DIV_W-1:0]    num,
    input  wire logic [31:0]                   den,
    output logic                               done,
    output logic [kpvb_pkg::DIV_W-1:0]         quo
);

    localparam int CNT_W = $clog2(kpvb_pkg::DIV_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [kpvb_pkg::DIV_W-1:0]  dq_reg;
    logic [31:0]                 rem_reg;
    logic [31:0]                 den_reg;
    logic [32:0]                 trial;
    logic [32:0]                 diff;
    logic                        ge;

    always_comb begin
        trial = {rem_reg, dq_reg[kpvb_pkg::DIV_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(kpvb_pkg::DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            dq_reg  <= {dq_reg[kpvb_pkg::DIV_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = dq_reg;

endmodule

`default_nettype wire

### rtl/kalman_pos_vel_baro_filter.sv
// Six-state position/velocity Kalman filter with a barometric altitude update.
// Request channel s_*, result channel m_*, APB-style register port.
// One request is worked on at a time; it yields exactly one result with the
// state after the step and the gain of the last effective baro update.
// Work per request, on the shared multiply unit and the one-bit-per-cycle
// gain divider:
//   init      loads the 36-entry covariance store,
//   predict   9 state steps and 42 covariance elements,
//   update    six 48-bit gain divisions, then 48 elements,
//   predict or update before any init, or an unused op: no work, result only.
// s_ready is high only while no request is in work; a new request is taken only
// once the last is finished. A finished result sits in an output register,
// so the next request is accepted while m_valid waits on m_ready; a request
// that finishes before then holds until the output register frees.
// Reset (synchronous, aresetn low) clears state, gains and the started flag and
// loads the register defaults; the covariance store is loaded by init. Registers
// 0..7 lie at byte addresses 0x00..0x1C; the user must write them only while idle,
// the block does not enforce it. Depends on kpvb_pkg, kpvb_mac and kpvb_div.
`default_nettype none

module kalman_pos_vel_baro_filter (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_op,
    input  wire logic signed [31:0] s_init_px,
    input  wire logic signed [31:0] s_init_py,
    input  wire logic signed [31:0] s_init_pz,
    input  wire logic signed [31:0] s_init_vx,
    input  wire logic signed [31:0] s_init_vy,
    input  wire logic signed [31:0] s_init_vz,
    input  wire logic signed [31:0] s_accel_x,
    input  wire logic signed [31:0] s_accel_y,
    input  wire logic signed [31:0] s_accel_z,
    input  wire logic [16:0]        s_step_time,
    input  wire logic signed [31:0] s_alt_sample,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_est_px,
    output logic signed [31:0]      m_est_py,
    output logic signed [31:0]      m_est_pz,
    output logic signed [31:0]      m_est_vx,
    output logic signed [31:0]      m_est_vy,
    output logic signed [31:0]      m_est_vz,
    output logic signed [31:0]      m_gain_0,
    output logic signed [31:0]      m_gain_1,
    output logic signed [31:0]      m_gain_2,
    output logic signed [31:0]      m_gain_3,
    output logic signed [31:0]      m_gain_4,
    output logic signed [31:0]      m_gain_5,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int NX = kpvb_pkg::NX;

    kpvb_pkg::phase_t ph_reg;
    kpvb_pkg::step_t  st_reg;
    logic [2:0]       i_reg;
    logic [2:0]       j_reg;
    logic             started_reg;
    logic             m_valid_reg;
    logic [30:0]      cfg_reg [kpvb_pkg::NUM_CFG];
    logic signed [31:0] x_reg    [NX];
    logic signed [31:0] gain_reg [NX];

    logic signed [31:0] accel_reg [3];
    logic [16:0]        dt_reg;
    logic signed [31:0] alt_reg;
    logic [kpvb_pkg::DT2_W-1:0] dt2_reg;
    logic signed [31:0] opa_reg;
    logic signed [31:0] c_reg;
    logic [31:0]        s_reg;
    logic signed [31:0] resid_reg;
    logic signed [31:0] row1_reg [NX];
    logic               sign_reg;
    logic signed [31:0] est_out_reg  [NX];
    logic signed [31:0] gain_out_reg [NX];

    logic signed [31:0] cov_mem [NX*NX];
    logic signed [31:0] mem_rdata_reg;

    logic                        cfg_wr;
    logic [2:0]                  imax;
    logic [2:0]                  jmax;
    kpvb_pkg::phase_t            ph_after;
    logic [2:0]                  i_next;
    logic [2:0]                  j_next;
    kpvb_pkg::phase_t            ph_next;
    logic [kpvb_pkg::ADDR_W-1:0] a_addr;
    logic [kpvb_pkg::ADDR_W-1:0] c_addr;
    logic [kpvb_pkg::ADDR_W-1:0] raddr;
    logic                        mem_we;
    logic signed [31:0]          mem_wdata;
    logic [2:0]                  xidx;
    logic signed [31:0]          x_sel;
    logic signed [31:0]          opa_src;
    logic signed [31:0]          opb_sel;
    logic signed [31:0]          c_src;
    kpvb_pkg::mac_ctl_t          mac_ctl;
    logic signed [31:0]          mac_y;
    logic                        x_we;
    logic                        fin_fire;
    logic signed [33:0]          s_sum;
    logic                        s_pos;
    logic signed [32:0]          resid_wide;
    logic [31:0]                 mag;
    logic [kpvb_pkg::DIV_W-1:0]  div_num;
    logic                        div_start;
    logic                        div_done;
    logic [kpvb_pkg::DIV_W-1:0]  div_quo;
    logic signed [31:0]          gain_sat;

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = {1'b0, cfg_reg[paddr[4:2]]};
    assign s_ready  = (ph_reg == kpvb_pkg::PH_IDLE);
    assign m_valid  = m_valid_reg;
    assign fin_fire = (ph_reg == kpvb_pkg::PH_FIN) && (!m_valid_reg || m_ready);

    // Loop bounds and successor of each phase.
    always_comb begin
        imax     = 3'd0;
        jmax     = 3'd0;
        ph_after = kpvb_pkg::PH_FIN;
        unique case (ph_reg)
            kpvb_pkg::PH_CLR:  begin imax = 3'd5; jmax = 3'd5; end
            kpvb_pkg::PH_DT2:  ph_after = kpvb_pkg::PH_PST;
            kpvb_pkg::PH_PST:  begin imax = 3'd2; jmax = 3'd2; ph_after = kpvb_pkg::PH_CA; end
            kpvb_pkg::PH_CA:   begin imax = 3'd2; jmax = 3'd5; ph_after = kpvb_pkg::PH_CB; end
            kpvb_pkg::PH_CB:   begin imax = 3'd5; jmax = 3'd2; ph_after = kpvb_pkg::PH_CQ; end
            kpvb_pkg::PH_CQ:   imax = 3'd5;
            kpvb_pkg::PH_GAIN: begin imax = 3'd5; ph_after = kpvb_pkg::PH_RES; end
            kpvb_pkg::PH_XUPD: begin imax = 3'd5; ph_after = kpvb_pkg::PH_ROW1; end
            kpvb_pkg::PH_ROW1: begin jmax = 3'd5; ph_after = kpvb_pkg::PH_CUPD; end
            kpvb_pkg::PH_CUPD: begin imax = 3'd5; jmax = 3'd5; end
            default: ;
        endcase
    end

    always_comb begin
        i_next  = i_reg;
        j_next  = j_reg;
        ph_next = ph_reg;
        if (j_reg == jmax) begin
            j_next = 3'd0;
            if (i_reg == imax) begin
                i_next  = 3'd0;
                ph_next = ph_after;
            end else begin
                i_next = i_reg + 3'd1;
            end
        end else begin
            j_next = j_reg + 3'd1;
        end
    end

    // Operand selection for the shared multiply unit.
    always_comb begin
        xidx  = ((st_reg == kpvb_pkg::ST_RB) ||
                 ((ph_reg == kpvb_pkg::PH_PST) && (j_reg == 3'd2))) ? (i_reg + 3'd3) : i_reg;
        x_sel = x_reg[xidx];

        a_addr = kpvb_pkg::cov_idx(i_reg + 3'd3, j_reg);
        c_addr = kpvb_pkg::cov_idx(i_reg, j_reg);
        opa_src = mem_rdata_reg;
        opb_sel = 32'sd0;
        c_src   = mem_rdata_reg;
        mac_ctl.op = kpvb_pkg::POST_ADD;
        x_we    = 1'b0;
        unique case (ph_reg)
            kpvb_pkg::PH_DT2: begin
                opa_src = {15'd0, dt_reg};
                opb_sel = {15'd0, dt_reg};
                c_src   = 32'sd0;
            end
            kpvb_pkg::PH_PST: begin
                opa_src = (j_reg == 3'd1) ? x_sel : accel_reg[i_reg[1:0]];
                opb_sel = (j_reg == 3'd0) ? {13'd0, dt2_reg} : {15'd0, dt_reg};
                c_src   = x_sel;
                x_we    = (j_reg != 3'd0);
                case (j_reg)
                    3'd0:    mac_ctl.op = kpvb_pkg::POST_HOLD;
                    3'd1:    mac_ctl.op = kpvb_pkg::POST_POS;
                    default: mac_ctl.op = kpvb_pkg::POST_ADD;
                endcase
            end
            kpvb_pkg::PH_CA: opb_sel = {15'd0, dt_reg};
            kpvb_pkg::PH_CB: begin
                a_addr  = kpvb_pkg::cov_idx(i_reg, j_reg + 3'd3);
                opb_sel = {15'd0, dt_reg};
            end
            kpvb_pkg::PH_CQ: begin
                c_addr  = kpvb_pkg::cov_idx(i_reg, i_reg);
                opa_src = {1'b0, cfg_reg[i_reg]};
                opb_sel = 32'sd1 <<< kpvb_pkg::FRAC_BITS;
            end
            kpvb_pkg::PH_S:    a_addr = kpvb_pkg::cov_idx(3'd1, 3'd1);
            kpvb_pkg::PH_GAIN: a_addr = kpvb_pkg::cov_idx(i_reg, 3'd1);
            kpvb_pkg::PH_XUPD: begin
                opa_src = gain_reg[i_reg];
                opb_sel = resid_reg;
                c_src   = x_sel;
                x_we    = 1'b1;
            end
            kpvb_pkg::PH_ROW1: a_addr = kpvb_pkg::cov_idx(3'd1, j_reg);
            kpvb_pkg::PH_CUPD: begin
                opa_src    = gain_reg[i_reg];
                opb_sel    = row1_reg[j_reg];
                mac_ctl.op = kpvb_pkg::POST_SUB;
            end
            default: ;
        endcase
        mac_ctl.mul_en  = (st_reg == kpvb_pkg::ST_MUL);
        mac_ctl.hold_en = (st_reg == kpvb_pkg::ST_POST) && (ph_reg == kpvb_pkg::PH_PST) &&
                          (j_reg == 3'd0);
        raddr = (st_reg == kpvb_pkg::ST_RA) ? a_addr : c_addr;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = mac_y;
        if (ph_reg == kpvb_pkg::PH_CLR) begin
            mem_we    = 1'b1;
            mem_wdata = (i_reg == j_reg) ? {1'b0, cfg_reg[kpvb_pkg::CFG_INIT_COV]} : 32'sd0;
        end else if (st_reg == kpvb_pkg::ST_POST) begin
            mem_we = (ph_reg == kpvb_pkg::PH_CA) || (ph_reg == kpvb_pkg::PH_CB) ||
                     (ph_reg == kpvb_pkg::PH_CQ) || (ph_reg == kpvb_pkg::PH_CUPD);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cov_mem[c_addr] <= mem_wdata;
        end
        mem_rdata_reg <= cov_mem[raddr];
    end

    kpvb_mac u_mac (
        .aclk   (aclk),
        .ctl    (mac_ctl),
        .opa    (opa_reg),
        .opb    (opb_sel),
        .addend (c_reg),
        .y      (mac_y)
    );

    // Innovation variance, residual, the gain division operands and the saturated gain.
    always_comb begin
        s_sum = {{2{mem_rdata_reg[31]}}, mem_rdata_reg} +
                {3'b000, cfg_reg[kpvb_pkg::CFG_MEAS_NOISE]};
        s_pos = !s_sum[33] && (s_sum != 34'sd0);
        resid_wide = {alt_reg[31], alt_reg} - {x_reg[1][31], x_reg[1]};
        mag = mem_rdata_reg[31] ? (~mem_rdata_reg + 32'd1) : mem_rdata_reg;
        div_num = {mag, {kpvb_pkg::FRAC_BITS{1'b0}}} +
                  {{kpvb_pkg::FRAC_BITS{1'b0}}, 1'b0, s_reg[31:1]};
        div_start = (ph_reg == kpvb_pkg::PH_GAIN) && (st_reg == kpvb_pkg::ST_RB);
        if (!sign_reg) begin
            gain_sat = (|div_quo[kpvb_pkg::DIV_W-1:31]) ? 32'sh7FFF_FFFF : div_quo[31:0];
        end else begin
            gain_sat = ((|div_quo[kpvb_pkg::DIV_W-1:32]) || (div_quo[31] && |div_quo[30:0])) ?
                       32'sh8000_0000 : -div_quo[31:0];
        end
    end

    kpvb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (s_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg      <= kpvb_pkg::PH_IDLE;
            st_reg      <= kpvb_pkg::ST_RA;
            i_reg       <= 3'd0;
            j_reg       <= 3'd0;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < kpvb_pkg::NUM_CFG; k++) begin
                cfg_reg[k] <= kpvb_pkg::CFG_RESET[k];
            end
            for (int k = 0; k < NX; k++) begin
                x_reg[k]    <= 32'sd0;
                gain_reg[k] <= 32'sd0;
            end
        end else begin
            if (cfg_wr) begin
                cfg_reg[paddr[4:2]] <= pwdata[30:0];
            end
            if (fin_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (ph_reg)
                kpvb_pkg::PH_IDLE: begin
                    if (s_valid) begin
                        st_reg <= kpvb_pkg::ST_RA;
                        i_reg  <= 3'd0;
                        j_reg  <= 3'd0;
                        if (s_op == kpvb_pkg::OP_INIT) begin
                            x_reg[0]    <= s_init_px;
                            x_reg[1]    <= s_init_py;
                            x_reg[2]    <= s_init_pz;
                            x_reg[3]    <= s_init_vx;
                            x_reg[4]    <= s_init_vy;
                            x_reg[5]    <= s_init_vz;
                            started_reg <= 1'b1;
                            ph_reg      <= kpvb_pkg::PH_CLR;
                        end else if (s_op == kpvb_pkg::OP_PREDICT && started_reg) begin
                            ph_reg <= kpvb_pkg::PH_DT2;
                        end else if (s_op == kpvb_pkg::OP_UPDATE && started_reg) begin
                            ph_reg <= kpvb_pkg::PH_S;
                        end else begin
                            ph_reg <= kpvb_pkg::PH_FIN;
                        end
                    end
                end
                kpvb_pkg::PH_CLR: begin
                    i_reg  <= i_next;
                    j_reg  <= j_next;
                    ph_reg <= ph_next;
                end
                kpvb_pkg::PH_S: begin
                    if (st_reg == kpvb_pkg::ST_RA) begin
                        st_reg <= kpvb_pkg::ST_RB;
                    end else begin
                        // A non-positive innovation variance leaves everything as it is.
                        st_reg <= kpvb_pkg::ST_RA;
                        ph_reg <= s_pos ? kpvb_pkg::PH_GAIN : kpvb_pkg::PH_FIN;
                    end
                end
                kpvb_pkg::PH_RES: begin
                    ph_reg <= kpvb_pkg::PH_XUPD;
                end
                kpvb_pkg::PH_FIN: begin
                    if (fin_fire) begin
                        ph_reg <= kpvb_pkg::PH_IDLE;
                    end
                end
                default: begin
                    unique case (st_reg)
                        kpvb_pkg::ST_RA: st_reg <= kpvb_pkg::ST_RB;
                        kpvb_pkg::ST_RB: st_reg <= kpvb_pkg::ST_MUL;
                        kpvb_pkg::ST_MUL: begin
                            if (ph_reg != kpvb_pkg::PH_GAIN || div_done) begin
                                st_reg <= kpvb_pkg::ST_POST;
                            end
                        end
                        kpvb_pkg::ST_POST: begin
                            st_reg <= kpvb_pkg::ST_RA;
                            i_reg  <= i_next;
                            j_reg  <= j_next;
                            ph_reg <= ph_next;
                            if (x_we) begin
                                x_reg[xidx] <= mac_y;
                            end
                            if (ph_reg == kpvb_pkg::PH_GAIN) begin
                                gain_reg[i_reg] <= gain_sat;
                            end
                        end
                        default: st_reg <= kpvb_pkg::ST_RA;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            accel_reg[0] <= s_accel_x;
            accel_reg[1] <= s_accel_y;
            accel_reg[2] <= s_accel_z;
            dt_reg       <= s_step_time;
            alt_reg      <= s_alt_sample;
        end
        if (st_reg == kpvb_pkg::ST_RB) begin
            opa_reg <= opa_src;
        end
        if (st_reg == kpvb_pkg::ST_MUL) begin
            c_reg <= c_src;
        end
        if (ph_reg == kpvb_pkg::PH_DT2 && st_reg == kpvb_pkg::ST_POST) begin
            dt2_reg <= mac_y[kpvb_pkg::DT2_W-1:0];
        end
        if (ph_reg == kpvb_pkg::PH_S && st_reg == kpvb_pkg::ST_RB) begin
            s_reg <= s_sum[31:0];
        end
        if (ph_reg == kpvb_pkg::PH_RES) begin
            resid_reg <= kpvb_pkg::sat32({{33{resid_wide[32]}}, resid_wide});
        end
        if (ph_reg == kpvb_pkg::PH_ROW1 && st_reg == kpvb_pkg::ST_RB) begin
            row1_reg[j_reg] <= mem_rdata_reg;
        end
        if (div_start) begin
            sign_reg <= mem_rdata_reg[31];
        end
        if (fin_fire) begin
            for (int k = 0; k < NX; k++) begin
                est_out_reg[k]  <= x_reg[k];
                gain_out_reg[k] <= gain_reg[k];
            end
        end
    end

    assign m_est_px = est_out_reg[0];
    assign m_est_py = est_out_reg[1];
    assign m_est_pz = est_out_reg[2];
    assign m_est_vx = est_out_reg[3];
    assign m_est_vy = est_out_reg[4];
    assign m_est_vz = est_out_reg[5];
    assign m_gain_0 = gain_out_reg[0];
    assign m_gain_1 = gain_out_reg[1];
    assign m_gain_2 = gain_out_reg[2];
    assign m_gain_3 = gain_out_reg[3];
    assign m_gain_4 = gain_out_reg[4];
    assign m_gain_5 = gain_out_reg[5];

endmodule

`default_nettype wire

### rtl/kpvb_checker.sv
// Port-level checks for the Kalman filter top level, bound to it below.
// Depends on kalman_pos_vel_baro_filter.
`default_nettype none

module kpvb_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [31:0] m_est_py,
    input wire logic signed [31:0] m_gain_1
);

    // A result that waits keeps its valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped while stalled");

    // A result that waits keeps its payload (checked on m_est_py and m_gain_1).
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_est_py) && $stable(m_gain_1))
        else $error("result payload changed while stalled");

    // Each request is worked on alone: the block closes right after accepting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in work");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind kalman_pos_vel_baro_filter kpvb_checker u_kpvb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_est_py (m_est_py),
    .m_gain_1 (m_gain_1)
);

`default_nettype wire
